// ===== design/config_text_tokenizer_unit_macros.svh =====
// Assertion macros shared by the tokenizer modules
`ifndef CONFIG_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_UNIT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");
// next-cycle implication
`define CTT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");
`endif

// ===== design/ctt_pkg.sv =====
// Package: types and constants of the configuration text tokenizer
package ctt_pkg;
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_LINECMT = 3'd1,
		MODE_BLKCMT  = 3'd2,
		MODE_QUOTED  = 3'd3,
		MODE_BARE    = 3'd4,
		MODE_HEREDOC = 3'd5
	} mode_t;

	localparam logic [2:0] KIND_PUNCT  = 3'd0;
	localparam logic [2:0] KIND_BYTE   = 3'd1;
	localparam logic [2:0] KIND_STREND = 3'd2;
	localparam logic [2:0] KIND_ERROR  = 3'd3;
	localparam logic [2:0] KIND_EOI    = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_NEWLINE = 3'd1;
	localparam logic [2:0] ERR_END     = 3'd2;
	localparam logic [2:0] ERR_SLASH   = 3'd3;
	localparam logic [2:0] ERR_PLUS    = 3'd4;

	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  token_byte;
		logic [2:0]  error_code;
		logic [15:0] line_number;
		logic        last_of_run;
	} out_item_t;

	// one result slot, line number attached in the front part
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  tbyte;
		logic [2:0]  err;
		logic [15:0] line;
	} res_t;

	// front-to-back record: up to four results of one item
	typedef struct packed {
		logic [2:0]   count;
		res_t [3:0]   res;
	} group_t;

	function automatic logic [7:0] unescape(input logic [7:0] s);
		logic [7:0] r;
		begin
			r = s;
			if (s >= "1" && s <= "9") r = 8'd128 + (s - 8'h30);
			else case (s)
				"n": r = 8'd10;
				"t": r = 8'd9;
				"a": r = 8'd7;
				"b": r = 8'd8;
				"0": r = 8'd0;
				"K": r = 8'd128;
				"T": r = 8'd138;
				"N": r = 8'd139;
				"H": r = 8'd140;
				"E": r = 8'd141;
				"S": r = 8'd142;
				"C": r = 8'd143;
				default: r = s;
			endcase
			return r;
		end
	endfunction
endpackage

// ===== design/config_text_tokenizer_unit.sv =====
// Top level of the configuration text tokenizer
//  channel | direction | handshake        | payload
//  input   | in        | push / full      | in_item  (text_byte, end_of_input)
//  result  | out       | empty / pop      | result   (kind, byte, error, line, last)
//  config  | in        | cfg_we           | cfg_data (spaces_in_bare_strings)
// One byte is taken every cycle while the two-entry group queue has room.
// Each byte yields zero to four results; they drain at one per cycle while pop is held.
// A byte's results are formed when the next byte is taken; a byte with no result
// leaves nothing in the queue. Reset is asynchronous and clears all control state.
module config_text_tokenizer_unit #(
	parameter int LINE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ctt_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output ctt_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic               cfg_data
);
	logic spaces_q, in_go, gfull;
	ctt_pkg::group_t grp;

	assign full = gfull;
	assign in_go = push && !gfull;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spaces_q <= 1'b0;
		else if (cfg_we) spaces_q <= cfg_data;
	end

	ctt_front #(.LINE_BITS(LINE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .spaces_q(spaces_q), .in_go(in_go),
		.in_item(in_item), .grp(grp)
	);

	ctt_back u_back (
		.clk(clk), .arst_n(arst_n), .grp_push(in_go && grp.count != 3'd0),
		.grp_in(grp), .grp_full(gfull), .empty(empty), .pop(pop), .result(result)
	);
endmodule

// ===== design/ctt_front.sv =====
// Front part: scanner state, lookahead and classification into result groups
module ctt_front #(
	parameter int LINE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               spaces_q,
	input  logic               in_go,
	input  ctt_pkg::in_item_t  in_item,
	output ctt_pkg::group_t    grp
);
	ctt_pkg::mode_t mode_q, mode_d;
	logic qsingle_q, qsingle_d, hsingle_q, hsingle_d;
	logic [7:0] held_q, held_d;
	logic hvalid_q, hvalid_d, skip_q, skip_d, cont_q, cont_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

	logic [7:0] b;
	logic endf;
	ctt_pkg::group_t g;

	function automatic logic [15:0] show(input logic [LINE_BITS-1:0] l);
		logic [15:0] r;
		begin
			if (LINE_BITS > 16 && (l >> 16) != '0) r = 16'hFFFF;
			else r = 16'(l);
			return r;
		end
	endfunction

	always_comb begin
		logic hv, took, eb, isr;
		logic [7:0] c, la;
		b = in_item.text_byte;
		endf = in_item.end_of_input || b == 8'd0;
		mode_d = mode_q; qsingle_d = qsingle_q; hsingle_d = hsingle_q;
		held_d = held_q; hvalid_d = hvalid_q; skip_d = skip_q; cont_d = cont_q;
		line_d = line_q;
		g = '0;
		took = 1'b0;
		eb = 1'b0;
		isr = 1'b0;
		hv = hvalid_q && !skip_q;
		if (hvalid_q && skip_q) begin
			hvalid_d = 1'b0; skip_d = 1'b0;
		end
		c = held_q;
		la = endf ? 8'd0 : b;
		if (hv) begin
			isr = 1'b0;
			if (c != 8'h0D) begin
				case (mode_d)
					ctt_pkg::MODE_LINECMT: begin
						if (c == 8'h0A) begin
							if (line_d != LINE_TOP) line_d = line_d + 1'b1;
							mode_d = ctt_pkg::MODE_IDLE;
						end
					end
					ctt_pkg::MODE_BLKCMT: begin
						if (c == 8'h0A && line_d != LINE_TOP) line_d = line_d + 1'b1;
						if (c == "*" && la == "/") begin
							mode_d = ctt_pkg::MODE_IDLE; took = 1'b1;
						end
					end
					ctt_pkg::MODE_QUOTED: begin
						if (c == 8'h0C || c == 8'h0A) begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0,
								ctt_pkg::ERR_NEWLINE, show(line_d)};
							g.count = g.count + 1'b1;
							mode_d = ctt_pkg::MODE_IDLE;
						end else if (c == "\\") begin
							if (la == 8'd0) begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0,
									ctt_pkg::ERR_END, show(line_d)};
								g.count = g.count + 1'b1;
								mode_d = ctt_pkg::MODE_IDLE;
							end else if (la == 8'h0D || la == 8'h0A) begin
								if (line_d != LINE_TOP) line_d = line_d + 1'b1;
								cont_d = 1'b1; took = 1'b1;
							end else begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_BYTE,
									ctt_pkg::unescape(la), ctt_pkg::ERR_NONE, show(line_d)};
								g.count = g.count + 1'b1;
								took = 1'b1;
							end
						end else if ((c == "\"" && !qsingle_d) || (c == "'" && qsingle_d)) begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_STREND, 8'd0,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
							mode_d = ctt_pkg::MODE_IDLE;
						end else begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_BYTE, c,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
						end
					end
					ctt_pkg::MODE_HEREDOC: begin
						if (c == (hsingle_d ? 8'h27 : 8'h22) && la == "@") begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_STREND, 8'd0,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
							mode_d = ctt_pkg::MODE_IDLE; took = 1'b1;
						end else begin
							if (c == 8'h0A && line_d != LINE_TOP) line_d = line_d + 1'b1;
							g.res[g.count[1:0]] = {ctt_pkg::KIND_BYTE, c,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
						end
					end
					ctt_pkg::MODE_BARE: begin
						eb = (!spaces_q && (c == 8'h20 || c == 8'h09)) ||
							c inside {8'h22, 8'h27, 8'h0A, 8'h0C, "=", "{", "}", "(", ")",
								"+", ",", "#", "/", ";"};
						if (eb) begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_STREND, 8'd0,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
							mode_d = ctt_pkg::MODE_IDLE;
							isr = 1'b1;
						end else begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_BYTE, c,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
						end
					end
					default: begin
						mode_d = ctt_pkg::MODE_IDLE; isr = 1'b1;
					end
				endcase
				if (isr) begin
					case (c)
						";", " ", 8'h0C, 8'h09: ;
						8'h0A: if (line_d != LINE_TOP) line_d = line_d + 1'b1;
						"#": mode_d = ctt_pkg::MODE_LINECMT;
						"/": begin
							if (la == "/" || la == "*") begin
								mode_d = (la == "/") ? ctt_pkg::MODE_LINECMT
									: ctt_pkg::MODE_BLKCMT;
								took = 1'b1;
							end else begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0,
									ctt_pkg::ERR_SLASH, show(line_d)};
								g.count = g.count + 1'b1;
							end
						end
						"{", "}", "(", ")", "=", ",": begin
							g.res[g.count[1:0]] = {ctt_pkg::KIND_PUNCT, c,
								ctt_pkg::ERR_NONE, show(line_d)};
							g.count = g.count + 1'b1;
						end
						"+": begin
							if (la == "=") begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_PUNCT, c,
									ctt_pkg::ERR_NONE, show(line_d)};
								took = 1'b1;
							end else begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0,
									ctt_pkg::ERR_PLUS, show(line_d)};
							end
							g.count = g.count + 1'b1;
						end
						8'h22, 8'h27: begin
							mode_d = ctt_pkg::MODE_QUOTED;
							qsingle_d = (c == 8'h27);
						end
						default: begin
							if (c == "@" && (la == 8'h22 || la == 8'h27)) begin
								hsingle_d = (la == 8'h27);
								mode_d = ctt_pkg::MODE_HEREDOC;
								took = 1'b1;
							end else begin
								g.res[g.count[1:0]] = {ctt_pkg::KIND_BYTE, c,
									ctt_pkg::ERR_NONE, show(line_d)};
								g.count = g.count + 1'b1;
								mode_d = ctt_pkg::MODE_BARE;
							end
						end
					endcase
				end
			end
		end
		if (!endf) begin
			if (hv) begin
				held_d = b; hvalid_d = 1'b1; skip_d = took;
			end else if (cont_q && (b == 8'h20 || b == 8'h09 || b == 8'h0A ||
					b == 8'h0B || b == 8'h0C || b == 8'h0D)) begin
				cont_d = cont_q;
			end else begin
				cont_d = 1'b0; held_d = b; hvalid_d = 1'b1;
			end
		end else begin
			if (cont_d) begin
				g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_END,
					show(line_d)};
				g.count = g.count + 1'b1;
				mode_d = ctt_pkg::MODE_IDLE;
			end
			if (mode_d == ctt_pkg::MODE_QUOTED || mode_d == ctt_pkg::MODE_HEREDOC) begin
				g.res[g.count[1:0]] = {ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_END,
					show(line_d)};
				g.count = g.count + 1'b1;
			end else if (mode_d == ctt_pkg::MODE_BARE) begin
				g.res[g.count[1:0]] = {ctt_pkg::KIND_STREND, 8'd0, ctt_pkg::ERR_NONE,
					show(line_d)};
				g.count = g.count + 1'b1;
			end
			g.res[g.count[1:0]] = {ctt_pkg::KIND_EOI, 8'd0, ctt_pkg::ERR_NONE,
				show(line_d)};
			g.count = g.count + 1'b1;
			mode_d = ctt_pkg::MODE_IDLE; qsingle_d = 1'b0; hsingle_d = 1'b0;
			held_d = 8'd0; hvalid_d = 1'b0; skip_d = 1'b0; cont_d = 1'b0;
			line_d = LINE_BITS'(1);
		end
	end

	assign grp = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctt_pkg::MODE_IDLE;
			qsingle_q <= 1'b0; hsingle_q <= 1'b0;
			held_q <= 8'd0; hvalid_q <= 1'b0; skip_q <= 1'b0; cont_q <= 1'b0;
			line_q <= LINE_BITS'(1);
		end else if (in_go) begin
			mode_q <= mode_d;
			qsingle_q <= qsingle_d; hsingle_q <= hsingle_d;
			held_q <= held_d; hvalid_q <= hvalid_d; skip_q <= skip_d; cont_q <= cont_d;
			line_q <= line_d;
		end
	end

	`include "config_text_tokenizer_unit_macros.svh"
	`CTT_ASSERT_IMP(a_line_nonzero, 1'b1, line_q != '0)
	`CTT_ASSERT_IMP(a_grp_bound, in_go, grp.count <= 3'(ctt_pkg::MAX_RES))
	`CTT_ASSERT_NXT(a_eoi_clears, in_go && (in_item.end_of_input || in_item.text_byte == 8'd0),
		!hvalid_q && mode_q == ctt_pkg::MODE_IDLE)
endmodule

// ===== design/ctt_back.sv =====
// Back part: group queue and serialisation of results onto the output
module ctt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              grp_push,
	input  ctt_pkg::group_t   grp_in,
	output logic              grp_full,
	output logic              empty,
	input  logic              pop,
	output ctt_pkg::out_item_t result
);
	ctt_pkg::group_t ent_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	logic [1:0] sub_q;
	logic rd_go, last;
	ctt_pkg::group_t head;
	ctt_pkg::res_t r;

	assign head = ent_q[rd_q];
	assign r = head.res[sub_q];
	assign empty = cnt_q == 2'd0;
	assign grp_full = cnt_q == 2'd2;
	assign last = (3'(sub_q) + 3'd1) == head.count;
	assign rd_go = pop && !empty && last;
	assign result = {r.kind, r.tbyte, r.err, r.line, last};

	always_ff @(posedge clk) begin
		if (grp_push) ent_q[wr_q] <= grp_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0; wr_q <= 1'b0; rd_q <= 1'b0; sub_q <= 2'd0;
		end else begin
			if (grp_push) wr_q <= !wr_q;
			if (pop && !empty) sub_q <= last ? 2'd0 : sub_q + 2'd1;
			if (rd_go) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, grp_push} - {1'b0, rd_go};
		end
	end

	`include "config_text_tokenizer_unit_macros.svh"
	`CTT_ASSERT_IMP(a_no_overflow, grp_push, !grp_full)
	`CTT_ASSERT_IMP(a_head_nonempty, !empty, head.count != 3'd0)
	`CTT_ASSERT_IMP(a_sub_in_range, !empty, 3'(sub_q) < head.count)
endmodule

// ===== dv/tb_config_text_tokenizer_unit.sv =====
// Testbench for the configuration text tokenizer: directed and random byte streams
module tb_config_text_tokenizer_unit;
	localparam int LINE_MAX = 65535;
	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	ctt_pkg::in_item_t in_item;
	logic empty;
	logic pop;
	ctt_pkg::out_item_t result;
	logic cfg_we;
	logic cfg_data;

	config_text_tokenizer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// predictor state
	logic            spaces_ok;
	ctt_pkg::mode_t  mode;
	logic            q_single;
	logic            hd_single;
	logic [7:0]      held;
	logic            held_ok;
	logic            skip_la;
	logic            cont_skip;
	int              lines;

	ctt_pkg::out_item_t token_q[$];
	int         n_fail;
	int         n_results;
	int         n_items;
	int         stall_long;
	int         quiet;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		mode = ctt_pkg::MODE_IDLE;
		q_single = 0;
		hd_single = 0;
		held = 0;
		held_ok = 0;
		skip_la = 0;
		cont_skip = 0;
		lines = 1;
	endfunction

	function automatic void bump_line();
		if (lines < LINE_MAX)
			lines++;
	endfunction

	function automatic void add_token(logic [2:0] k, logic [7:0] b, logic [2:0] e);
		ctt_pkg::out_item_t r;
		r.result_kind = k;
		r.token_byte = b;
		r.error_code = e;
		r.line_number = lines[15:0];
		r.last_of_run = 0;
		token_q.push_back(r);
	endfunction

	function automatic logic [7:0] escape_value(logic [7:0] s);
		if (s >= "1" && s <= "9")
			return 8'd128 + (s - "0");
		case (s)
			"n": return 8'd10;
			"t": return 8'd9;
			"a": return 8'd7;
			"b": return 8'd8;
			"0": return 8'd0;
			"K": return 8'd128;
			"T": return 8'd138;
			"N": return 8'd139;
			"H": return 8'd140;
			"E": return 8'd141;
			"S": return 8'd142;
			"C": return 8'd143;
			default: return s;
		endcase
	endfunction

	function automatic bit idle_scan(logic [7:0] c, logic [7:0] la);
		case (c)
			";", " ", 8'h0c, 8'h09: return 0;
			8'h0a: begin
				bump_line();
				return 0;
			end
			"#": begin
				mode = ctt_pkg::MODE_LINECMT;
				return 0;
			end
			"/": begin
				if (la == "/" || la == "*") begin
					mode = (la == "/") ? ctt_pkg::MODE_LINECMT : ctt_pkg::MODE_BLKCMT;
					return 1;
				end
				add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_SLASH);
				return 0;
			end
			"{", "}", "(", ")", "=", ",": begin
				add_token(ctt_pkg::KIND_PUNCT, c, ctt_pkg::ERR_NONE);
				return 0;
			end
			"+": begin
				if (la == "=") begin
					add_token(ctt_pkg::KIND_PUNCT, "+", ctt_pkg::ERR_NONE);
					return 1;
				end
				add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_PLUS);
				return 0;
			end
			"\"", "'": begin
				mode = ctt_pkg::MODE_QUOTED;
				q_single = (c == "'");
				return 0;
			end
			"@": begin
				if (la == "\"" || la == "'") begin
					hd_single = (la == "'");
					mode = ctt_pkg::MODE_HEREDOC;
					return 1;
				end
			end
			default: ;
		endcase
		add_token(ctt_pkg::KIND_BYTE, c, ctt_pkg::ERR_NONE);
		mode = ctt_pkg::MODE_BARE;
		return 0;
	endfunction

	function automatic bit ends_bare(logic [7:0] c);
		if (!spaces_ok && (c == " " || c == 8'h09))
			return 1;
		case (c)
			"\"", "'", 8'h0a, 8'h0c, "=", "{", "}", "(", ")", "+", ",", "#", "/", ";":
				return 1;
			default: return 0;
		endcase
	endfunction

	function automatic bit scan_char(logic [7:0] c, logic [7:0] la);
		if (c == 8'h0d)
			return 0;
		case (mode)
			ctt_pkg::MODE_LINECMT: begin
				if (c == 8'h0a) begin
					bump_line();
					mode = ctt_pkg::MODE_IDLE;
				end
				return 0;
			end
			ctt_pkg::MODE_BLKCMT: begin
				if (c == 8'h0a)
					bump_line();
				if (c == "*" && la == "/") begin
					mode = ctt_pkg::MODE_IDLE;
					return 1;
				end
				return 0;
			end
			ctt_pkg::MODE_QUOTED: begin
				if (c == 8'h0c || c == 8'h0a) begin
					add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_NEWLINE);
					mode = ctt_pkg::MODE_IDLE;
					return 0;
				end
				if (c == "\\") begin
					if (la == 0) begin
						add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_END);
						mode = ctt_pkg::MODE_IDLE;
						return 0;
					end
					if (la == 8'h0d || la == 8'h0a) begin
						bump_line();
						cont_skip = 1;
						return 1;
					end
					add_token(ctt_pkg::KIND_BYTE, escape_value(la), ctt_pkg::ERR_NONE);
					return 1;
				end
				if ((c == "\"" && !q_single) || (c == "'" && q_single)) begin
					add_token(ctt_pkg::KIND_STREND, 8'd0, ctt_pkg::ERR_NONE);
					mode = ctt_pkg::MODE_IDLE;
					return 0;
				end
				add_token(ctt_pkg::KIND_BYTE, c, ctt_pkg::ERR_NONE);
				return 0;
			end
			ctt_pkg::MODE_BARE: begin
				if (ends_bare(c)) begin
					add_token(ctt_pkg::KIND_STREND, 8'd0, ctt_pkg::ERR_NONE);
					mode = ctt_pkg::MODE_IDLE;
					return idle_scan(c, la);
				end
				add_token(ctt_pkg::KIND_BYTE, c, ctt_pkg::ERR_NONE);
				return 0;
			end
			ctt_pkg::MODE_HEREDOC: begin
				if (c == (hd_single ? 8'h27 : 8'h22) && la == "@") begin
					add_token(ctt_pkg::KIND_STREND, 8'd0, ctt_pkg::ERR_NONE);
					mode = ctt_pkg::MODE_IDLE;
					return 1;
				end
				if (c == 8'h0a)
					bump_line();
				add_token(ctt_pkg::KIND_BYTE, c, ctt_pkg::ERR_NONE);
				return 0;
			end
			default: begin
				mode = ctt_pkg::MODE_IDLE;
				return idle_scan(c, la);
			end
		endcase
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c || b == 8'h0d;
	endfunction

	function automatic void predict_tokens(ctt_pkg::in_item_t it);
		int base;
		bit took;
		base = token_q.size();
		if (held_ok && skip_la) begin
			held_ok = 0;
			skip_la = 0;
		end
		if (!(it.end_of_input || it.text_byte == 0)) begin
			if (held_ok) begin
				took = scan_char(held, it.text_byte);
				held = it.text_byte;
				skip_la = took;
			end else if (cont_skip && is_blank(it.text_byte)) begin
			end else begin
				cont_skip = 0;
				held = it.text_byte;
				held_ok = 1;
			end
		end else begin
			if (held_ok)
				took = scan_char(held, 8'd0);
			held_ok = 0;
			skip_la = 0;
			if (cont_skip) begin
				add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_END);
				mode = ctt_pkg::MODE_IDLE;
				cont_skip = 0;
			end
			if (mode == ctt_pkg::MODE_QUOTED || mode == ctt_pkg::MODE_HEREDOC)
				add_token(ctt_pkg::KIND_ERROR, 8'd0, ctt_pkg::ERR_END);
			else if (mode == ctt_pkg::MODE_BARE)
				add_token(ctt_pkg::KIND_STREND, 8'd0, ctt_pkg::ERR_NONE);
			add_token(ctt_pkg::KIND_EOI, 8'd0, ctt_pkg::ERR_NONE);
			clear_scan();
		end
		if (token_q.size() > base)
			token_q[token_q.size() - 1].last_of_run = 1;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		ctt_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (token_q.size() == 0) begin
				$error("result with nothing expected: kind %0d", result.result_kind);
				n_fail++;
			end else begin
				want = token_q.pop_front();
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind exp %0d got %0d", want.result_kind, result.result_kind);
					n_fail++;
				end
				if (result.token_byte !== want.token_byte) begin
					$error("token_byte exp %0d got %0d", want.token_byte, result.token_byte);
					n_fail++;
				end
				if (result.error_code !== want.error_code) begin
					$error("error_code exp %0d got %0d", want.error_code, result.error_code);
					n_fail++;
				end
				if (result.line_number !== want.line_number) begin
					$error("line_number exp %0d got %0d", want.line_number, result.line_number);
					n_fail++;
				end
				if (result.last_of_run !== want.last_of_run) begin
					$error("last_of_run exp %0d got %0d", want.last_of_run, result.last_of_run);
					n_fail++;
				end
			end
		end
		if (!arst_n)
			pop <= 0;
		else if (stall_long > 0) begin
			stall_long--;
			pop <= 0;
		end else
			pop <= ($urandom_range(0, 3) != 0) || (($urandom_range(0, 1) == 0) && pop);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n && ((push && !full) || (pop && !empty) || (token_q.size() == 0 && !push)))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic eoi);
		ctt_pkg::in_item_t it;
		it.text_byte = b;
		it.end_of_input = eoi;
		push <= 1;
		in_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_tokens(it);
		n_items++;
		if ($urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic set_spaces(logic v);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		spaces_ok = v;
	endtask

	task automatic test_punctuation();
		send_text("a = { b , c } ( d ) x += 1; # c\n// c\n/* c\n */ / + - ");
		send_byte(8'd0, 1'b0);
	endtask

	task automatic test_strings();
		send_text("\"a\\n\\t\\a\\b\\0\\K\\1\\9\\T\\N\\H\\E\\S\\C\\q\" 'it\\'s'");
		send_text(" \"x\\\015\n \t y\" \"bad\nz\" \015\n/**/ */ @\"h\n\"@ @'q\"'@ @x");
		send_text(" \"\\");
		send_byte(8'hff, 1'b1);
		send_text("'open");
		send_byte(8'h80, 1'b1);
		send_text("@\"op");
		send_byte(8'd0, 1'b1);
		send_text("\"\\\n");
		send_byte(8'd0, 1'b1);
	endtask

	task automatic test_bare_spaces();
		send_text("key word\tz\fw=1");
		send_byte(8'd0, 1'b1);
	endtask

	task automatic test_line_count();
		repeat (20)
			send_byte(8'h0a, 1'b0);
		send_text("x\n\"s\ny");
		send_byte(8'd0, 1'b1);
	endtask

	function automatic logic [7:0] pick_byte();
		string alpha;
		alpha = "ab1=+/*#@\"'\\{}(),; \t\n\015\fnK9";
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(1, 255));
		return alpha[$urandom_range(0, alpha.len() - 1)];
	endfunction

	task automatic test_random(int count);
		int burst;
		for (int i = 0; i < count; i++) begin
			burst = $urandom_range(1, 12);
			if ($urandom_range(0, 40) == 0)
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			else
				send_byte(pick_byte(), 1'b0);
			if (i % burst == 0) begin
				push <= 0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end
		end
		send_byte(8'd0, 1'b1);
	endtask

	task automatic test_backpressure();
		stall_long = 60;
		for (int i = 0; i < 40; i++)
			send_byte(pick_byte(), 1'b0);
		send_byte(8'd0, 1'b1);
		drain();
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_data = 0;
		n_fail = 0;
		n_results = 0;
		n_items = 0;
		stall_long = 0;
		quiet = 0;
		spaces_ok = 0;
		clear_scan();
		repeat (9)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_punctuation();
		test_strings();
		test_bare_spaces();
		drain();
		set_spaces(1);
		test_bare_spaces();
		test_random(40);
		drain();
		set_spaces(0);
		test_random(40);
		drain();
		test_backpressure();
		set_spaces(1);
		test_line_count();
		drain();
		$display("Sent %0d bytes, checked %0d results", n_items, n_results);
		$display("Covered punctuation, comments, strings, escapes, heredocs, errors, stalls");
		if (n_fail == 0 && token_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
